[rtl/core/open_addressing_hash_table_core_assert.svh]
// assertion helpers shared by the datapath and controller modules
// each use expects clk and rst_n in the enclosing scope
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH

// plain property, sampled on clk, off while in reset
`define OAHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define OAHT_ASSERT_IMP(lbl, cond, expr, msg) \
  `OAHT_ASSERT(lbl, (cond) |-> (expr), msg)

`endif

[rtl/core/oaht_pkg.sv]
`timescale 1ns / 1ps

package oaht_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int HASH_W      = KEY_W - 1;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int MEM_W       = 1 + KEY_W + DATA_W;

  // remainder unit: bits retired per cycle
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CYCLES  = (HASH_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_PAD_W   = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_DONE
  } oaht_state_t;

  typedef enum logic [1:0] {
    RES_INSERTED,
    RES_FOUND,
    RES_FULL,
    RES_MISS
  } oaht_res_t;

  // controller to datapath
  typedef struct packed {
    logic      clr_wr;
    logic      req_load;
    logic      pos_load;
    logic      mem_rd;
    logic      ins_wr;
    logic      advance;
    logic      res_load;
    oaht_res_t res_kind;
  } oaht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic table_full;
    logic req_search;
    logic slot_valid;
    logic key_match;
    logic probe_last;
    logic out_free;
  } oaht_sts_t;

  // size register clamped to 1..TABLE_DEPTH
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] cfg);
    logic [SIZE_W-1:0] s;
    s = cfg;
    if (cfg == '0) begin
      s = SIZE_W'(1);
    end else if (cfg > SIZE_W'(TABLE_DEPTH)) begin
      s = SIZE_W'(TABLE_DEPTH);
    end
    return s;
  endfunction

endpackage

[rtl/core/oaht_if.sv]
`timescale 1ns / 1ps

// request word channel
interface oaht_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [oaht_pkg::KEY_W-1:0] key;
  logic [oaht_pkg::DATA_W-1:0]     record_data;

  modport source (output valid, output req_type, output key, output record_data,
                  input ready);
  modport sink (input valid, input req_type, input key, input record_data,
                output ready);
endinterface

// result word channel
interface oaht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [oaht_pkg::STATUS_W-1:0] status;
  logic [oaht_pkg::DATA_W-1:0]   found_data;
  logic [oaht_pkg::IDX_W-1:0]    slot_index;

  modport source (output valid, output status, output found_data, output slot_index,
                  input ready);
  modport sink (input valid, input status, input found_data, input slot_index,
                output ready);
endinterface

[rtl/core/oaht_mod_unit.sv]
`timescale 1ns / 1ps

// hashed key modulo table size, DIV_STEPS remainder bits per cycle
module oaht_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [oaht_pkg::HASH_W-1:0]   dividend,
  input  logic [oaht_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [oaht_pkg::IDX_W-1:0]    rem
);
  import oaht_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_PAD_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [IDX_W-1:0]     step_rem;

  // restoring remainder steps, top bits first
  always_comb begin
    logic [SIZE_W-1:0] t;
    logic [IDX_W-1:0]  r;
    r = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, sh_r[DIV_PAD_W-1-i]};
      if (t >= divisor) begin
        t = t - divisor;
      end
      r = t[IDX_W-1:0];
    end
    step_rem = r;
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = DIV_PAD_W'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = step_rem;
      sh_nxt  = sh_r << DIV_STEPS;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands, no reset
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[rtl/core/oaht_datapath.sv]
`timescale 1ns / 1ps
`include "open_addressing_hash_table_core_assert.svh"

// slot store, request registers, probe pointer, entry count and result register
module oaht_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [oaht_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                              in_req_type,
  input  logic signed [oaht_pkg::KEY_W-1:0] in_key,
  input  logic [oaht_pkg::DATA_W-1:0]       in_record_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oaht_pkg::STATUS_W-1:0]     out_status,
  output logic [oaht_pkg::DATA_W-1:0]       out_found_data,
  output logic [oaht_pkg::IDX_W-1:0]        out_slot_index,
  input  oaht_pkg::oaht_cmd_t               cmd,
  output oaht_pkg::oaht_sts_t               sts
);
  import oaht_pkg::*;

  logic [SIZE_W-1:0]   size_cfg_r;
  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]    clr_addr_r;
  logic                req_search_r;
  logic [KEY_W-1:0]    req_key_r;
  logic [DATA_W-1:0]   req_data_r;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    probe_r, probe_nxt;
  logic [SIZE_W-1:0]   pos_inc;
  logic [SIZE_W-1:0]   probe_inc;
  logic [SIZE_W-1:0]   pos_ext;
  logic                div_done;
  logic [IDX_W-1:0]    div_rem;

  logic [MEM_W-1:0]    slot_mem [TABLE_DEPTH];
  logic [MEM_W-1:0]    rd_q_r;
  logic                mem_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [MEM_W-1:0]    wr_word;
  logic                rd_valid;
  logic [KEY_W-1:0]    rd_key;
  logic [DATA_W-1:0]   rd_data;

  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [DATA_W-1:0]         out_data_r, out_data_nxt;
  logic [IDX_W-1:0]          out_slot_r, out_slot_nxt;

  assign size_eff = eff_size(size_cfg_r);

  // size register, clearing pointer and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= SIZE_W'(TABLE_DEPTH);
      clr_addr_r <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        size_cfg_r <= cfg_wdata;
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign count_nxt = cmd.ins_wr ? count_r + SIZE_W'(1) : count_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_search_r <= (in_req_type == REQ_SEARCH);
      req_key_r    <= in_key;
      req_data_r   <= in_record_data;
    end
  end

  // home slot
  oaht_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.req_load),
    .dividend (in_key[HASH_W-1:0]),
    .divisor  (size_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // probe pointer with wrap at the active size
  assign pos_ext   = {1'b0, pos_r};
  assign pos_inc   = pos_ext + SIZE_W'(1);
  assign probe_inc = {1'b0, probe_r} + SIZE_W'(1);

  always_comb begin
    pos_nxt   = pos_r;
    probe_nxt = probe_r;
    if (cmd.pos_load) begin
      pos_nxt   = div_rem;
      probe_nxt = '0;
    end else if (cmd.advance) begin
      pos_nxt   = (pos_inc == size_eff) ? '0 : pos_inc[IDX_W-1:0];
      probe_nxt = probe_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    probe_r <= probe_nxt;
  end

  // slot store: valid, key, record in one word
  assign mem_we  = cmd.clr_wr | cmd.ins_wr;
  assign wr_addr = cmd.clr_wr ? clr_addr_r : pos_r;
  assign wr_word = cmd.clr_wr ? '0 : {1'b1, req_key_r, req_data_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_word;
    end
    if (cmd.mem_rd) begin
      rd_q_r <= slot_mem[pos_r];
    end
  end

  assign rd_valid = rd_q_r[MEM_W-1];
  assign rd_key   = rd_q_r[KEY_W+DATA_W-1:DATA_W];
  assign rd_data  = rd_q_r[DATA_W-1:0];

  // status to controller
  always_comb begin
    sts.clr_last   = (clr_addr_r == IDX_W'(TABLE_DEPTH - 1));
    sts.div_done   = div_done;
    sts.table_full = (count_r >= size_eff);
    sts.req_search = req_search_r;
    sts.slot_valid = rd_valid;
    sts.key_match  = (rd_key == req_key_r);
    sts.probe_last = (probe_inc == size_eff);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // result word register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_slot_nxt   = out_slot_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
      case (cmd.res_kind)
        RES_INSERTED: begin
          out_status_nxt = STATUS_OK;
          out_data_nxt   = '0;
          out_slot_nxt   = pos_r;
        end
        RES_FOUND: begin
          out_status_nxt = STATUS_OK;
          out_data_nxt   = rd_data;
          out_slot_nxt   = pos_r;
        end
        RES_FULL: begin
          out_status_nxt = STATUS_FULL;
          out_data_nxt   = '0;
          out_slot_nxt   = '0;
        end
        default: begin
          out_status_nxt = STATUS_MISS;
          out_data_nxt   = '0;
          out_slot_nxt   = '0;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_data = out_data_r;
  assign out_slot_index = out_slot_r;

  // checks
  `OAHT_ASSERT_IMP(a_no_result_overwrite, cmd.res_load, !out_valid_r || out_ready, "result word overwritten before taken")
  `OAHT_ASSERT_IMP(a_insert_into_empty, cmd.ins_wr, !rd_valid, "insert wrote over an occupied slot")
  `OAHT_ASSERT_IMP(a_probe_in_range, cmd.mem_rd, pos_ext < size_eff, "probe outside active slots")
  `OAHT_ASSERT(a_count_bound, count_r <= SIZE_W'(TABLE_DEPTH), "entry count above table depth")

endmodule

[rtl/core/oaht_ctrl.sv]
`timescale 1ns / 1ps
`include "open_addressing_hash_table_core_assert.svh"

// sequencer: clearing pass, hashing, probe loop, result hand-off
module oaht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oaht_pkg::oaht_sts_t sts,
  output oaht_pkg::oaht_cmd_t cmd
);
  import oaht_pkg::*;

  oaht_state_t state_r, state_nxt;
  oaht_res_t   res_r, res_nxt;

  // next state and result kind
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.div_done) begin
          if (!sts.req_search && sts.table_full) begin
            res_nxt   = RES_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        if (!sts.slot_valid) begin
          res_nxt = sts.req_search ? RES_MISS : RES_INSERTED;
        end else if (sts.req_search && sts.key_match) begin
          res_nxt = RES_FOUND;
        end else if (sts.probe_last) begin
          res_nxt = sts.req_search ? RES_MISS : RES_FULL;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.res_kind = res_r;
    in_ready     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
      end
      S_HASH: begin
        cmd.pos_load = sts.div_done;
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
      end
      S_EVAL: begin
        cmd.ins_wr  = !sts.req_search && !sts.slot_valid;
        cmd.advance = sts.slot_valid && !(sts.req_search && sts.key_match)
                      && !sts.probe_last;
      end
      S_DONE: begin
        cmd.res_load = sts.out_free;
      end
      default: begin
        cmd.res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= RES_MISS;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // checks
  `OAHT_ASSERT_IMP(a_one_write_source, cmd.clr_wr, !cmd.ins_wr && !in_ready, "clearing overlaps request work")
  `OAHT_ASSERT(a_eval_after_read, (state_r == S_EVAL) |-> ($past(state_r) == S_READ), "slot evaluated without a read")
  `OAHT_ASSERT(a_single_step, !(cmd.advance && cmd.ins_wr), "probe advanced while inserting")

endmodule

[rtl/core/open_addressing_hash_table_core.sv]
// Hash table with open addressing and linear probing, 1024 slots of key and record.
// in_req: request word (req_type 0 insert, 1 search; key; record_data), valid/ready.
// out_rsp: one result word per request (status, found_data, slot_index), valid/ready.
// cfg_we/cfg_wdata: writes the active slot count (0 acts as 1, above 1024 acts as
// 1024); write only while no request is in flight.
// Per request the home slot is (key & 0x7FFFFFFF) mod size, taken by a remainder unit
// that retires four bits a cycle. Slots are then probed one at a time, each probe a
// registered read of the slot store, then a compare.
// An insert into a full table is answered without probing. A new request can be taken
// in the cycle after the result is loaded, not earlier.
// Reset: synchronous, active low. Afterwards a clearing pass marks all 1024 slots empty,
// one slot per cycle; in_req.ready stays low until the pass ends.
// The result sits in an output register; while the receiver stalls, the next request is
// still accepted and processed, and only its result waits for the register to free up.
`timescale 1ns / 1ps

module open_addressing_hash_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [oaht_pkg::SIZE_W-1:0]   cfg_wdata,
  oaht_req_if.sink                      in_req,
  oaht_rsp_if.source                    out_rsp
);
  import oaht_pkg::*;

  oaht_cmd_t cmd;
  oaht_sts_t sts;
  logic      in_ready;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oaht_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req.req_type),
    .in_key         (in_req.key),
    .in_record_data (in_req.record_data),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_status     (out_rsp.status),
    .out_found_data (out_rsp.found_data),
    .out_slot_index (out_rsp.slot_index),
    .cmd            (cmd),
    .sts            (sts)
  );

  assign in_req.ready = in_ready;

endmodule
